/* hw/rtl/zts_pkg.sv */
// ----------------------------------------------------------------------------
// zts_pkg: shared types and codes of the zone transfer record sequencer
// Transaction structs, phase/command/error codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package zts_pkg;

    localparam int unsigned SERIAL_W   = 32;
    localparam int unsigned COUNT_W    = 10;
    localparam int unsigned CMD_W      = 4;
    localparam int unsigned ERR_W      = 3;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned MAX_RES    = 3;

    localparam logic [COUNT_W-1:0] BATCH_LIMIT_RESET = COUNT_W'(100);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_INCREMENTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REQUESTED_SERIAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT         = 2'd2;

    typedef enum logic [3:0] {
        PH_INIT   = 4'd0,
        PH_FIRST  = 4'd1,
        PH_DELSOA = 4'd2,
        PH_DEL    = 4'd3,
        PH_ADDSOA = 4'd4,
        PH_ADD    = 4'd5,
        PH_FULL   = 4'd6,
        PH_END    = 4'd7,
        PH_FAILED = 4'd8
    } phase_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE        = 4'd0,
        CMD_BEGIN_FULL  = 4'd1,
        CMD_BEGIN_INCR  = 4'd2,
        CMD_PUT_DEL     = 4'd3,
        CMD_PUT_ADD     = 4'd4,
        CMD_FLUSH       = 4'd5,
        CMD_COMMIT_INCR = 4'd6,
        CMD_COMMIT_FULL = 4'd7,
        CMD_ERROR       = 4'd8
    } cmd_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE       = 3'd0,
        ERR_UP_TO_DATE = 3'd1,
        ERR_EXTRA_DATA = 3'd2,
        ERR_NON_SOA    = 3'd3,
        ERR_FAILED     = 3'd4
    } err_t;

    typedef struct packed {
        logic                record_is_soa;
        logic [SERIAL_W-1:0] rec_serial;
    } in_item_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [ERR_W-1:0] error_code;
        logic             transfer_done;
        logic             last;
    } out_item_t;

    // sequencer state carried between records
    typedef struct packed {
        phase_t              phase;
        logic [SERIAL_W-1:0] final_serial;
        logic [COUNT_W-1:0]  pending;
    } seq_state_t;

    // all results caused by one record
    typedef struct packed {
        logic [1:0]                  count;
        logic [MAX_RES-1:0][CMD_W-1:0] cmd;
        logic [ERR_W-1:0]            err;
        logic                        done;
    } step_res_t;

endpackage

`default_nettype wire

/* hw/rtl/zts_step.sv */
// ----------------------------------------------------------------------------
// zts_step: per-record decision logic
// Maps the current phase and one record to up to three commands and the
// next sequencer state. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module zts_step (
    input  var zts_pkg::seq_state_t              cur,
    input  var zts_pkg::in_item_t                item,
    input  var logic                             request_incremental,
    input  var logic [zts_pkg::SERIAL_W-1:0]     requested_serial,
    input  var logic [zts_pkg::COUNT_W-1:0]      batch_limit,
    output zts_pkg::seq_state_t                  nxt,
    output zts_pkg::step_res_t                   res
);
    import zts_pkg::*;

    logic [SERIAL_W-1:0] serial_diff;
    logic                serial_newer;
    logic [COUNT_W:0]    count_inc;
    logic                flush_cur;
    logic                flush_zero;
    logic [COUNT_W-1:0]  count_cur;
    logic [COUNT_W-1:0]  count_zero;

    // RFC 1982 comparison: requested serial is older than the new one
    assign serial_diff  = item.rec_serial - requested_serial;
    assign serial_newer = (serial_diff != '0) && !serial_diff[SERIAL_W-1];

    // put bookkeeping from the current count and from a cleared count
    assign count_inc  = {1'b0, cur.pending} + {{COUNT_W{1'b0}}, 1'b1};
    assign flush_cur  = count_inc > {1'b0, batch_limit};
    assign count_cur  = flush_cur ? '0 : count_inc[COUNT_W-1:0];
    assign flush_zero = (batch_limit == '0);
    assign count_zero = flush_zero ? '0 : {{(COUNT_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        nxt       = cur;
        res.count = 2'd1;
        res.cmd   = '0;
        res.err   = ERR_NONE;

        case (cur.phase)
            PH_INIT:
            begin
                if (!item.record_is_soa)
                begin
                    res.cmd[0] = CMD_ERROR;
                    res.err    = ERR_NON_SOA;
                    nxt.phase  = PH_FAILED;
                end
                else
                begin
                    nxt.final_serial = item.rec_serial;
                    if (request_incremental && !serial_newer)
                    begin
                        res.cmd[0] = CMD_ERROR;
                        res.err    = ERR_UP_TO_DATE;
                        nxt.phase  = PH_FAILED;
                    end
                    else
                    begin
                        res.cmd[0] = CMD_NONE;
                        nxt.phase  = PH_FIRST;
                    end
                end
            end
            PH_FIRST:
            begin
                // second record picks incremental or full
                res.cmd[0]  = item.record_is_soa ? CMD_BEGIN_INCR : CMD_BEGIN_FULL;
                res.cmd[1]  = item.record_is_soa ? CMD_PUT_DEL : CMD_PUT_ADD;
                res.cmd[2]  = CMD_FLUSH;
                res.count   = flush_zero ? 2'd3 : 2'd2;
                nxt.pending = count_zero;
                nxt.phase   = item.record_is_soa ? PH_DEL : PH_FULL;
            end
            PH_DELSOA, PH_ADDSOA:
            begin
                if (!item.record_is_soa)
                begin
                    res.cmd[0] = CMD_ERROR;
                    res.err    = ERR_NON_SOA;
                    nxt.phase  = PH_FAILED;
                end
                else
                begin
                    res.cmd[0]  = (cur.phase == PH_DELSOA) ? CMD_PUT_DEL : CMD_PUT_ADD;
                    res.cmd[1]  = CMD_FLUSH;
                    res.count   = flush_cur ? 2'd2 : 2'd1;
                    nxt.pending = count_cur;
                    nxt.phase   = (cur.phase == PH_DELSOA) ? PH_DEL : PH_ADD;
                end
            end
            PH_DEL:
            begin
                res.cmd[0]  = item.record_is_soa ? CMD_PUT_ADD : CMD_PUT_DEL;
                res.cmd[1]  = CMD_FLUSH;
                res.count   = flush_cur ? 2'd2 : 2'd1;
                nxt.pending = count_cur;
                if (item.record_is_soa)
                begin
                    nxt.phase = PH_ADD;
                end
            end
            PH_ADD:
            begin
                if (item.record_is_soa)
                begin
                    // commit this sequence, then end or open the next one
                    res.cmd[0] = CMD_COMMIT_INCR;
                    if (item.rec_serial == cur.final_serial)
                    begin
                        nxt.pending = '0;
                        nxt.phase   = PH_END;
                    end
                    else
                    begin
                        res.cmd[1]  = CMD_PUT_DEL;
                        res.cmd[2]  = CMD_FLUSH;
                        res.count   = flush_zero ? 2'd3 : 2'd2;
                        nxt.pending = count_zero;
                        nxt.phase   = PH_DEL;
                    end
                end
                else
                begin
                    res.cmd[0]  = CMD_PUT_ADD;
                    res.cmd[1]  = CMD_FLUSH;
                    res.count   = flush_cur ? 2'd2 : 2'd1;
                    nxt.pending = count_cur;
                end
            end
            PH_FULL:
            begin
                res.cmd[0] = CMD_PUT_ADD;
                if (item.record_is_soa)
                begin
                    // closing SOA commits after any flush
                    res.cmd[1]  = flush_cur ? CMD_FLUSH : CMD_COMMIT_FULL;
                    res.cmd[2]  = CMD_COMMIT_FULL;
                    res.count   = flush_cur ? 2'd3 : 2'd2;
                    nxt.pending = '0;
                    nxt.phase   = PH_END;
                end
                else
                begin
                    res.cmd[1]  = CMD_FLUSH;
                    res.count   = flush_cur ? 2'd2 : 2'd1;
                    nxt.pending = count_cur;
                end
            end
            PH_END:
            begin
                res.cmd[0] = CMD_ERROR;
                res.err    = ERR_EXTRA_DATA;
                nxt.phase  = PH_FAILED;
            end
            default:
            begin
                res.cmd[0] = CMD_ERROR;
                res.err    = ERR_FAILED;
                nxt.phase  = PH_FAILED;
            end
        endcase

        res.done = (nxt.phase == PH_END);
    end

endmodule

`default_nettype wire

/* hw/rtl/zone_transfer_record_sequencer_top.sv */
// ----------------------------------------------------------------------------
// zone_transfer_record_sequencer_top: zone transfer record sequencer
// Turns the SOA/non-SOA records of an AXFR or IXFR response into begin,
// put, flush, commit and error commands.
// ----------------------------------------------------------------------------
// A record transaction is taken into an input register, decided by the step
// logic and then written to a result buffer that holds the one to three
// commands it causes. The buffer sends one command per cycle while out_stall
// is low, so a record occupies the output until all its commands (1 to 3)
// have left; the next record is taken while the buffer still drains and is
// decided the cycle its last command leaves. The first command of a record is
// presented once the record has passed from the input register into the
// result buffer. Error commands are always the only command of their record;
// after any error every record gives "already failed" until reset.
// Configuration writes take effect on the next record decided.
`default_nettype none

module zone_transfer_record_sequencer_top (
    input  var logic                              clk,
    input  var logic                              rst_n,
    input  var logic                              cfg_we,
    input  var logic [zts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  var logic [zts_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  var logic                              in_valid,
    output logic                                  in_stall,
    input  var zts_pkg::in_item_t                 in_data,
    output logic                                  out_valid,
    input  var logic                              out_stall,
    output zts_pkg::out_item_t                    out_data
);
    import zts_pkg::*;

    logic                          req_inc_reg;
    logic [SERIAL_W-1:0]           req_serial_reg;
    logic [COUNT_W-1:0]            limit_reg;
    seq_state_t                    state_reg;
    seq_state_t                    state_next;
    logic                          in_valid_reg;
    in_item_t                      in_data_reg;
    step_res_t                     step_res;
    logic                          res_valid_reg;
    logic [1:0]                    res_cnt_reg;
    logic [1:0]                    res_idx_reg;
    logic [MAX_RES-1:0][CMD_W-1:0] res_cmd_reg;
    logic [ERR_W-1:0]              res_err_reg;
    logic                          res_done_reg;
    logic                          res_last;
    logic                          res_drain;
    logic                          advance;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_inc_reg    <= 1'b0;
            req_serial_reg <= '0;
            limit_reg      <= BATCH_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REQUEST_INCREMENTAL: req_inc_reg    <= cfg_data[0];
                REG_REQUESTED_SERIAL:    req_serial_reg <= cfg_data[SERIAL_W-1:0];
                REG_BATCH_LIMIT:         limit_reg      <= cfg_data[COUNT_W-1:0];
                default:                 req_inc_reg    <= req_inc_reg;
            endcase
        end
    end

    // handshake: advance a record once the buffer empties or sends its last
    assign res_last  = (res_idx_reg == (res_cnt_reg - 2'd1));
    assign res_drain = res_valid_reg && !out_stall && res_last;
    assign advance   = in_valid_reg && (!res_valid_reg || res_drain);
    assign in_stall  = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    zts_step u_step (
        .cur                 (state_reg),
        .item                (in_data_reg),
        .request_incremental (req_inc_reg),
        .requested_serial    (req_serial_reg),
        .batch_limit         (limit_reg),
        .nxt                 (state_next),
        .res                 (step_res)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_INIT;
            state_reg.final_serial <= '0;
            state_reg.pending      <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // result buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            res_idx_reg   <= '0;
            res_cnt_reg   <= 2'd1;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
            res_idx_reg   <= '0;
            res_cnt_reg   <= step_res.count;
        end
        else if (res_valid_reg && !out_stall)
        begin
            if (res_last)
            begin
                res_valid_reg <= 1'b0;
            end
            else
            begin
                res_idx_reg <= res_idx_reg + 2'd1;
            end
        end
    end

    // result buffer payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_cmd_reg  <= step_res.cmd;
            res_err_reg  <= step_res.err;
            res_done_reg <= step_res.done;
        end
    end

    // drive the output transaction
    assign out_valid              = res_valid_reg;
    assign out_data.command       = res_cmd_reg[res_idx_reg];
    assign out_data.error_code    = res_err_reg;
    assign out_data.transfer_done = res_done_reg;
    assign out_data.last          = res_last;

`ifndef ASSERT_OFF
    // the buffer never points past its command count
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_idx_reg < res_cnt_reg))
        else $error("result index beyond command count");

    // an error command is the only command of its record
    a_error_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.command == CMD_ERROR)) |-> out_data.last)
        else $error("error command not last of its record");

    // the failed phase is left only through reset
    a_failed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_FAILED) |=> (state_reg.phase == PH_FAILED))
        else $error("failed phase was left");

    // stall only while a record waits in the input register
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && res_valid_reg))
        else $error("input stalled with nothing pending");
`endif

endmodule

`default_nettype wire

/* tb/zone_transfer_record_sequencer_top_tb.sv */
// ----------------------------------------------------------------------------
// zone_transfer_record_sequencer_top_tb: self-checking bench of the sequencer
// Drives one zone transfer response per run (full, incremental, stale or
// malformed, picked by the seed), predicts every command and compares the
// commands that leave the block field by field, under random idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module zone_transfer_record_sequencer_top_tb;

    import zts_pkg::*;

    localparam int unsigned DIRECTED_COUNT = 20;
    localparam int unsigned RANDOM_SEG_LEN = 100;
    localparam int unsigned SEG_COUNT      = 5;
    localparam int unsigned RECORD_COUNT   = DIRECTED_COUNT + (SEG_COUNT - 1) * RANDOM_SEG_LEN;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned LOG_CAP        = 40;

    // kind of response driven in this run
    typedef enum logic [1:0] {
        XFER_STALE  = 2'd0,
        XFER_NO_SOA = 2'd1,
        XFER_FULL   = 2'd2,
        XFER_INCR   = 2'd3
    } xfer_kind_t;

    // ------------------------------------------------------------------------
    // Command predictor and checker
    // ------------------------------------------------------------------------
    class transfer_command_checker;
        logic                request_incremental;
        logic [SERIAL_W-1:0] requested_serial;
        logic [COUNT_W-1:0]  batch_limit;
        phase_t              phase;
        logic [SERIAL_W-1:0] final_serial;
        logic [COUNT_W-1:0]  pending;
        out_item_t           expected_commands[$];
        int unsigned         mismatch_count;
        out_item_t           step_out[MAX_RES];
        int unsigned         step_n;

        function new();
            request_incremental = 1'b0;
            requested_serial    = '0;
            batch_limit         = BATCH_LIMIT_RESET;
            phase               = PH_INIT;
            final_serial        = '0;
            pending             = '0;
            mismatch_count      = 0;
            step_n              = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REQUEST_INCREMENTAL: request_incremental = data[0];
                REG_REQUESTED_SERIAL:    requested_serial    = data[SERIAL_W-1:0];
                REG_BATCH_LIMIT:         batch_limit         = data[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void emit(cmd_t cmd, err_t err);
            if (step_n < MAX_RES)
            begin
                step_out[step_n].command       = cmd;
                step_out[step_n].error_code    = err;
                step_out[step_n].transfer_done = 1'b0;
                step_out[step_n].last          = 1'b0;
                step_n++;
            end
        endfunction

        function void fail(err_t err);
            emit(CMD_ERROR, err);
            phase = PH_FAILED;
        endfunction

        // count one change; flush once the count goes above the limit
        function void put(cmd_t cmd);
            logic [COUNT_W:0] n;
            n = {1'b0, pending} + 1'b1;
            emit(cmd, ERR_NONE);
            if (n > {1'b0, batch_limit})
            begin
                emit(CMD_FLUSH, ERR_NONE);
                pending = '0;
            end
            else
            begin
                pending = n[COUNT_W-1:0];
            end
        endfunction

        // serial number arithmetic: a is ahead of b
        function bit serial_ahead(logic [SERIAL_W-1:0] a, logic [SERIAL_W-1:0] b);
            logic [SERIAL_W-1:0] d;
            d = a - b;
            return (d != '0) && (d < 32'h8000_0000);
        endfunction

        // advance the phase on one accepted record and queue its commands
        function void note_record(in_item_t rec);
            step_n = 0;
            case (phase)
                PH_INIT:
                begin
                    if (!rec.record_is_soa)
                    begin
                        fail(ERR_NON_SOA);
                    end
                    else
                    begin
                        final_serial = rec.rec_serial;
                        if (request_incremental &&
                            !serial_ahead(rec.rec_serial, requested_serial))
                        begin
                            fail(ERR_UP_TO_DATE);
                        end
                        else
                        begin
                            phase = PH_FIRST;
                            emit(CMD_NONE, ERR_NONE);
                        end
                    end
                end
                PH_FIRST:
                begin
                    pending = '0;
                    if (rec.record_is_soa)
                    begin
                        emit(CMD_BEGIN_INCR, ERR_NONE);
                        put(CMD_PUT_DEL);
                        phase = PH_DEL;
                    end
                    else
                    begin
                        emit(CMD_BEGIN_FULL, ERR_NONE);
                        put(CMD_PUT_ADD);
                        phase = PH_FULL;
                    end
                end
                PH_DELSOA:
                begin
                    if (!rec.record_is_soa)
                    begin
                        fail(ERR_NON_SOA);
                    end
                    else
                    begin
                        put(CMD_PUT_DEL);
                        phase = PH_DEL;
                    end
                end
                PH_DEL:
                begin
                    if (rec.record_is_soa)
                    begin
                        put(CMD_PUT_ADD);
                        phase = PH_ADD;
                    end
                    else
                    begin
                        put(CMD_PUT_DEL);
                    end
                end
                PH_ADDSOA:
                begin
                    if (!rec.record_is_soa)
                    begin
                        fail(ERR_NON_SOA);
                    end
                    else
                    begin
                        put(CMD_PUT_ADD);
                        phase = PH_ADD;
                    end
                end
                PH_ADD:
                begin
                    if (rec.record_is_soa)
                    begin
                        emit(CMD_COMMIT_INCR, ERR_NONE);
                        pending = '0;
                        if (rec.rec_serial == final_serial)
                        begin
                            phase = PH_END;
                        end
                        else
                        begin
                            put(CMD_PUT_DEL);
                            phase = PH_DEL;
                        end
                    end
                    else
                    begin
                        put(CMD_PUT_ADD);
                    end
                end
                PH_FULL:
                begin
                    put(CMD_PUT_ADD);
                    if (rec.record_is_soa)
                    begin
                        emit(CMD_COMMIT_FULL, ERR_NONE);
                        pending = '0;
                        phase = PH_END;
                    end
                end
                PH_END:
                begin
                    fail(ERR_EXTRA_DATA);
                end
                default:
                begin
                    phase = PH_FAILED;
                    emit(CMD_ERROR, ERR_FAILED);
                end
            endcase
            for (int unsigned k = 0; k < step_n; k++)
            begin
                step_out[k].transfer_done = (phase == PH_END);
                step_out[k].last          = (k == step_n - 1);
                expected_commands.push_back(step_out[k]);
            end
        endfunction

        task report_mismatch(string what);
            // keep the log short on a badly broken block
            if (mismatch_count < LOG_CAP)
                $display("%0t mismatch: %s", $time, what);
            mismatch_count++;
        endtask

        task check_command(out_item_t got);
            out_item_t want;
            if (expected_commands.size() == 0)
            begin
                report_mismatch($sformatf("command %0d with none pending", got.command));
                return;
            end
            want = expected_commands.pop_front();
            if (got.command !== want.command)
                report_mismatch($sformatf("command got %0d want %0d",
                                          got.command, want.command));
            if (got.error_code !== want.error_code)
                report_mismatch($sformatf("error_code got %0d want %0d",
                                          got.error_code, want.error_code));
            if (got.transfer_done !== want.transfer_done)
                report_mismatch($sformatf("transfer_done got %0b want %0b",
                                          got.transfer_done, want.transfer_done));
            if (got.last !== want.last)
                report_mismatch($sformatf("last got %0b want %0b", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;

    transfer_command_checker sb;
    xfer_kind_t              kind;
    logic [SERIAL_W-1:0]     target_serial;
    logic [SERIAL_W-1:0]     stale_serial;
    int unsigned             send_idle_pct = 0;
    int unsigned             recv_idle_pct = 0;

    zone_transfer_record_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // check each command transaction, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_command(out_data);
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // hard stop
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // serial with a bias toward the corners of the space
    function automatic logic [SERIAL_W-1:0] pick_serial();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // build the next record from the phase the transfer is in
    function automatic in_item_t next_record(int unsigned idx);
        in_item_t    rec;
        bit          closing;
        int unsigned soa_odds;
        closing           = (idx + 6 >= RECORD_COUNT);
        soa_odds          = (idx < DIRECTED_COUNT) ? 3 : 8;
        rec.record_is_soa = 1'b0;
        rec.rec_serial    = pick_serial();
        case (sb.phase)
            PH_INIT:
            begin
                rec.record_is_soa = (kind != XFER_NO_SOA);
                rec.rec_serial    = (kind == XFER_STALE) ? stale_serial : target_serial;
            end
            PH_FIRST: rec.record_is_soa = (kind == XFER_INCR);
            PH_DEL:   rec.record_is_soa = closing || ($urandom_range(1, soa_odds) == 1);
            PH_ADD:
            begin
                if (closing)
                begin
                    rec.record_is_soa = 1'b1;
                    rec.rec_serial    = sb.final_serial;
                end
                else if ($urandom_range(1, soa_odds) == 1)
                begin
                    // next difference sequence: must not hit the final serial
                    rec.record_is_soa = 1'b1;
                    if (rec.rec_serial == sb.final_serial)
                        rec.rec_serial = ~sb.final_serial;
                end
            end
            PH_FULL:  rec.record_is_soa = closing;
            default:  rec.record_is_soa = 1'($urandom_range(0, 1));
        endcase
        return rec;
    endfunction

    // send one record transaction, with a random gap ahead of it
    task automatic send_record(input in_item_t rec);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= rec;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_record(rec);
    endtask

    // hold input until every pending command is out, then let the block settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all three registers, or only the request registers
    task automatic configure(input logic req_incr, input logic [SERIAL_W-1:0] req_serial,
                             input logic [COUNT_W-1:0] limit, input bit with_limit);
        logic [CFG_IDX_W-1:0]  idx  [3];
        logic [CFG_DATA_W-1:0] data [3];
        int unsigned           n;
        idx[0]  = REG_REQUEST_INCREMENTAL;
        data[0] = CFG_DATA_W'(req_incr);
        idx[1]  = REG_REQUESTED_SERIAL;
        data[1] = req_serial;
        idx[2]  = REG_BATCH_LIMIT;
        data[2] = CFG_DATA_W'(limit);
        n = with_limit ? 3 : 2;
        for (int unsigned k = 0; k < n; k++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= data[k];
            @(posedge clk);
            sb.set_reg(idx[k], data[k]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned         pick;
        int unsigned         idx;
        int unsigned         seg_len;
        logic                req_incr;
        logic [SERIAL_W-1:0] req_serial;
        logic [COUNT_W-1:0]  limit;

        sb  = new();
        idx = 0;

        // hold reset, then release it
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pick the response kind and the serials around it
        pick = $urandom_range(0, 9);
        if (pick == 0)
            kind = XFER_STALE;
        else if (pick == 1)
            kind = XFER_NO_SOA;
        else if (pick < 6)
            kind = XFER_FULL;
        else
            kind = XFER_INCR;

        req_incr   = (kind == XFER_STALE) ? 1'b1 : 1'($urandom_range(0, 1));
        req_serial = pick_serial();
        case ($urandom_range(0, 3))
            0:       target_serial = req_serial + 32'd1;
            1:       target_serial = req_serial + 32'h7FFF_FFFF;
            default: target_serial = req_serial + $urandom_range(1, 32'h7FFF_FFFF);
        endcase
        if (!req_incr)
            target_serial = pick_serial();
        // equal, exactly half the space ahead, or behind
        case ($urandom_range(0, 2))
            0:       stale_serial = req_serial;
            1:       stale_serial = req_serial + 32'h8000_0000;
            default: stale_serial = req_serial - $urandom_range(1, 32'h7FFF_FFFF);
        endcase

        // batch limit stays at its reset value for the directed records
        configure(req_incr, req_serial, '0, 1'b0);

        for (int unsigned seg = 0; seg < SEG_COUNT; seg++)
        begin
            seg_len = (seg == 0) ? DIRECTED_COUNT : RANDOM_SEG_LEN;
            limit   = '0;
            case (seg)
                0, 1:
                begin
                    send_idle_pct = 38;
                    recv_idle_pct = 52;
                end
                2, 3:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 38;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (seg)
                1:       limit = '0;
                2:       limit = 10'd1023;
                3:       limit = COUNT_W'($urandom_range(2, 30));
                default: limit = 10'd1;
            endcase
            if (seg > 0)
            begin
                // request registers only matter on the first SOA; rewrite anyway
                wait_idle();
                configure(1'($urandom_range(0, 1)), pick_serial(), limit, 1'b1);
            end
            for (int unsigned k = 0; k < seg_len; k++)
            begin
                send_record(next_record(idx));
                idx++;
            end
        end

        wait_idle();
        if (sb.mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
